// ----- design/midc_pkg.sv -----
// Shared opcode constants and types for the MIPS instruction decoder.
`timescale 1ns / 1ps
`default_nettype none

package midc_pkg;

  localparam int unsigned OpW    = 6;
  localparam int unsigned RegW   = 5;
  localparam int unsigned WordW  = 32;
  localparam int unsigned TgtW   = 26;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [OpW-1:0]  op_t;
  typedef logic [RegW-1:0] reg_idx_t;

  // Major opcodes.
  localparam op_t OP_SPECIAL = 6'd0;
  localparam op_t OP_REGIMM  = 6'd1;
  localparam op_t OP_J       = 6'd2;
  localparam op_t OP_JAL     = 6'd3;
  localparam op_t OP_BEQ     = 6'd4;
  localparam op_t OP_BNE     = 6'd5;
  localparam op_t OP_BLEZ    = 6'd6;
  localparam op_t OP_BGTZ    = 6'd7;
  localparam op_t OP_ADDI    = 6'd8;
  localparam op_t OP_ADDIU   = 6'd9;
  localparam op_t OP_SLTI    = 6'd10;
  localparam op_t OP_SLTIU   = 6'd11;
  localparam op_t OP_ANDI    = 6'd12;
  localparam op_t OP_ORI     = 6'd13;
  localparam op_t OP_XORI    = 6'd14;
  localparam op_t OP_LUI     = 6'd15;
  localparam op_t OP_COP0    = 6'd16;
  localparam op_t OP_COP1    = 6'd17;
  localparam op_t OP_BEQL    = 6'd20;
  localparam op_t OP_BNEL    = 6'd21;
  localparam op_t OP_BLEZL   = 6'd22;
  localparam op_t OP_BGTZL   = 6'd23;
  localparam op_t OP_DADDI   = 6'd24;
  localparam op_t OP_DADDIU  = 6'd25;
  localparam op_t OP_LDL     = 6'd26;
  localparam op_t OP_LDR     = 6'd27;
  localparam op_t OP_JALX    = 6'd29;
  localparam op_t OP_LB      = 6'd32;
  localparam op_t OP_LH      = 6'd33;
  localparam op_t OP_LWL     = 6'd34;
  localparam op_t OP_LW      = 6'd35;
  localparam op_t OP_LBU     = 6'd36;
  localparam op_t OP_LHU     = 6'd37;
  localparam op_t OP_LWR     = 6'd38;
  localparam op_t OP_LWU     = 6'd39;
  localparam op_t OP_SB      = 6'd40;
  localparam op_t OP_SH      = 6'd41;
  localparam op_t OP_SWL     = 6'd42;
  localparam op_t OP_SW      = 6'd43;
  localparam op_t OP_SDL     = 6'd44;
  localparam op_t OP_SDR     = 6'd45;
  localparam op_t OP_SWR     = 6'd46;
  localparam op_t OP_CACHE   = 6'd47;
  localparam op_t OP_LL      = 6'd48;
  localparam op_t OP_PREF    = 6'd51;
  localparam op_t OP_LD      = 6'd55;
  localparam op_t OP_SC      = 6'd56;
  localparam op_t OP_SD      = 6'd63;

  // SPECIAL function codes.
  localparam op_t FN_SLL     = 6'd0;
  localparam op_t FN_SRL     = 6'd2;
  localparam op_t FN_SRA     = 6'd3;
  localparam op_t FN_SLLV    = 6'd4;
  localparam op_t FN_SRLV    = 6'd6;
  localparam op_t FN_SRAV    = 6'd7;
  localparam op_t FN_JR      = 6'd8;
  localparam op_t FN_JALR    = 6'd9;
  localparam op_t FN_MOVZ    = 6'd10;
  localparam op_t FN_MOVN    = 6'd11;
  localparam op_t FN_SYSCALL = 6'd12;
  localparam op_t FN_BREAK   = 6'd13;
  localparam op_t FN_SYNC    = 6'd15;
  localparam op_t FN_MFHI    = 6'd16;
  localparam op_t FN_MTHI    = 6'd17;
  localparam op_t FN_MFLO    = 6'd18;
  localparam op_t FN_MTLO    = 6'd19;
  localparam op_t FN_DSLLV   = 6'd20;
  localparam op_t FN_DSRLV   = 6'd22;
  localparam op_t FN_DSRAV   = 6'd23;
  localparam op_t FN_MULT    = 6'd24;
  localparam op_t FN_MULTU   = 6'd25;
  localparam op_t FN_DIV     = 6'd26;
  localparam op_t FN_DIVU    = 6'd27;
  localparam op_t FN_DMULT   = 6'd28;
  localparam op_t FN_DMULTU  = 6'd29;
  localparam op_t FN_DDIV    = 6'd30;
  localparam op_t FN_DDIVU   = 6'd31;
  localparam op_t FN_ADD     = 6'd32;
  localparam op_t FN_ADDU    = 6'd33;
  localparam op_t FN_SUB     = 6'd34;
  localparam op_t FN_SUBU    = 6'd35;
  localparam op_t FN_AND     = 6'd36;
  localparam op_t FN_OR      = 6'd37;
  localparam op_t FN_XOR     = 6'd38;
  localparam op_t FN_NOR     = 6'd39;
  localparam op_t FN_SLT     = 6'd42;
  localparam op_t FN_SLTU    = 6'd43;
  localparam op_t FN_DADD    = 6'd44;
  localparam op_t FN_DADDU   = 6'd45;
  localparam op_t FN_DSUB    = 6'd46;
  localparam op_t FN_DSUBU   = 6'd47;
  localparam op_t FN_DSLL    = 6'd56;
  localparam op_t FN_DSRL    = 6'd58;
  localparam op_t FN_DSRA    = 6'd59;
  localparam op_t FN_DSLL32  = 6'd60;
  localparam op_t FN_DSRL32  = 6'd62;
  localparam op_t FN_DSRA32  = 6'd63;

  // COP0 function codes in the CO form.
  localparam op_t C0_TLBR      = 6'd1;
  localparam op_t C0_TLBWI     = 6'd2;
  localparam op_t C0_TLBWR     = 6'd6;
  localparam op_t C0_TLBP      = 6'd8;
  localparam op_t C0_RFE       = 6'd16;
  localparam op_t C0_ERET      = 6'd24;
  localparam op_t C0_DERET     = 6'd31;
  localparam op_t C0_WAIT      = 6'd32;
  localparam op_t C0_STANDBY   = 6'd33;
  localparam op_t C0_SUSPEND   = 6'd34;
  localparam op_t C0_HIBERNATE = 6'd35;

  // COP0 rs sub-opcodes.
  localparam reg_idx_t RS_MF  = 5'd0;
  localparam reg_idx_t RS_DMF = 5'd1;
  localparam reg_idx_t RS_MT  = 5'd4;
  localparam reg_idx_t RS_DMT = 5'd5;

  // REGIMM rt sub-opcodes.
  localparam reg_idx_t RT_BLTZ   = 5'd0;
  localparam reg_idx_t RT_BGEZ   = 5'd1;
  localparam reg_idx_t RT_BLTZL  = 5'd2;
  localparam reg_idx_t RT_BGEZL  = 5'd3;
  localparam reg_idx_t RT_BLTZAL = 5'd16;
  localparam reg_idx_t RT_BGEZAL = 5'd17;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MIPS4  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_64BIT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ERET   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RFE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_POWER  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MIPS16 = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_FPU    = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_LLSC   = 3'd7;

  typedef struct packed {
    logic mips4;
    logic en64;
    logic eret;
    logic rfe;
    logic power;
    logic mips16;
    logic fpu;
    logic llsc;
  } cfg_t;

  // Feature-independent classification made in the middle stage.
  typedef struct packed {
    logic op_special;
    logic op_regimm;
    logic op_cop0;
    logic op_branch;
    logic op_jalx;
    logic op_likely;
    logic op_fpu;
    logic op_llsc;
    logic op_base;
    logic op_64;
    logic op_mips4;
    logic sp_ok;
    logic sp_ok64;
    logic sp_ok4;
    logic sp_jump;
    logic ri_br;
    logic ri_lk;
    logic c0_ok;
    logic c0_ok64;
    logic c0_co;
    logic co_ok;
    logic co_rfe;
    logic co_eret;
    logic co_wait;
    logic co_pwr;
    logic co_hib;
  } class_t;

endpackage

`default_nettype wire

// ----- design/mips_insn_decode_classify.sv -----
// Top level of the pipelined MIPS instruction decoder and classifier.
`timescale 1ns / 1ps
`default_nettype none

// A request is one instruction word with its address, taken at a rising
// clock edge where start is high and busy is low. busy never rises, so a
// request may be issued in every cycle.
// Three register stages: input capture, opcode/function classification,
// then the feature-switch combine into the result registers. The result of
// a request is marked by out_valid for exactly one cycle, and results leave
// in request order at one per cycle.
// The receiver cannot stall, so nothing is ever held back inside the block.
// Feature switches are written through cfg_we, cfg_index and cfg_wdata bit 0
// and should only change while no request is in flight.
// Synchronous reset clears the stage valid bits and all feature switches;
// the payload registers keep whatever they held.
// Fields that are plain bit slices of the word travel unchanged through the
// stages next to the classification.
module mips_insn_decode_classify (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [midc_pkg::WordW-1:0]     in_insn_word,
  input  wire logic [midc_pkg::WordW-1:0]     in_insn_address,
  input  wire logic                           cfg_we,
  input  wire logic [midc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic                           cfg_wdata,
  output logic                                out_valid,
  output logic                                out_recognized,
  output logic                                out_branch_flag,
  output logic                                out_likely_flag,
  output logic                                out_block_end,
  output logic [midc_pkg::WordW-1:0]          out_guest_pc,
  output logic [midc_pkg::OpW-1:0]            out_major_op,
  output logic [midc_pkg::RegW-1:0]           out_field_rs,
  output logic [midc_pkg::RegW-1:0]           out_field_rt,
  output logic [midc_pkg::RegW-1:0]           out_field_rd,
  output logic [midc_pkg::RegW-1:0]           out_shift_amount,
  output logic [midc_pkg::OpW-1:0]            out_function_code,
  output logic [midc_pkg::TgtW-1:0]           out_jump_target
);

  midc_pkg::cfg_t   cfg_r;

  logic                       s1_valid_r;
  logic [midc_pkg::WordW-1:0] s1_word_r;
  logic [midc_pkg::WordW-1:0] s1_pc_r;

  logic                       s2_valid_r;
  logic [midc_pkg::WordW-1:0] s2_word_r;
  logic [midc_pkg::WordW-1:0] s2_pc_r;
  midc_pkg::class_t           s2_cls_r;
  midc_pkg::class_t           s2_cls_nxt;

  logic                       out_valid_r;
  logic                       ok_nxt;
  logic                       br_nxt;
  logic                       lk_nxt;
  logic                       end_nxt;
  logic                       ok_r;
  logic                       br_r;
  logic                       lk_r;
  logic                       end_r;
  logic [midc_pkg::WordW-1:0] word_r;
  logic [midc_pkg::WordW-1:0] pc_r;

  midc_pkg::op_t     s1_op;
  midc_pkg::op_t     s1_fn;
  midc_pkg::reg_idx_t s1_rs;
  midc_pkg::reg_idx_t s1_rt;

  assign busy = 1'b0;

  // Feature switches.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        midc_pkg::CFG_MIPS4:  cfg_r.mips4  <= cfg_wdata;
        midc_pkg::CFG_64BIT:  cfg_r.en64   <= cfg_wdata;
        midc_pkg::CFG_ERET:   cfg_r.eret   <= cfg_wdata;
        midc_pkg::CFG_RFE:    cfg_r.rfe    <= cfg_wdata;
        midc_pkg::CFG_POWER:  cfg_r.power  <= cfg_wdata;
        midc_pkg::CFG_MIPS16: cfg_r.mips16 <= cfg_wdata;
        midc_pkg::CFG_FPU:    cfg_r.fpu    <= cfg_wdata;
        midc_pkg::CFG_LLSC:   cfg_r.llsc   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1: capture the request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_word_r <= in_insn_word;
    s1_pc_r   <= in_insn_address;
  end

  assign s1_op = s1_word_r[31:26];
  assign s1_rs = s1_word_r[25:21];
  assign s1_rt = s1_word_r[20:16];
  assign s1_fn = s1_word_r[5:0];

  // Stage 2: classify the opcode, function code and sub-opcodes.
  always_comb begin
    s2_cls_nxt = '0;

    unique case (s1_op) inside
      midc_pkg::OP_SPECIAL: s2_cls_nxt.op_special = 1'b1;
      midc_pkg::OP_REGIMM:  s2_cls_nxt.op_regimm  = 1'b1;
      midc_pkg::OP_COP0:    s2_cls_nxt.op_cop0    = 1'b1;
      midc_pkg::OP_J, midc_pkg::OP_JAL, midc_pkg::OP_BEQ, midc_pkg::OP_BNE,
      midc_pkg::OP_BLEZ, midc_pkg::OP_BGTZ:
        s2_cls_nxt.op_branch = 1'b1;
      midc_pkg::OP_JALX:    s2_cls_nxt.op_jalx    = 1'b1;
      midc_pkg::OP_BEQL, midc_pkg::OP_BNEL, midc_pkg::OP_BLEZL, midc_pkg::OP_BGTZL:
        s2_cls_nxt.op_likely = 1'b1;
      midc_pkg::OP_COP1:    s2_cls_nxt.op_fpu     = 1'b1;
      midc_pkg::OP_LL, midc_pkg::OP_SC:
        s2_cls_nxt.op_llsc = 1'b1;
      midc_pkg::OP_ADDI, midc_pkg::OP_ADDIU, midc_pkg::OP_SLTI, midc_pkg::OP_SLTIU,
      midc_pkg::OP_ANDI, midc_pkg::OP_ORI, midc_pkg::OP_XORI, midc_pkg::OP_LUI,
      midc_pkg::OP_LB, midc_pkg::OP_LH, midc_pkg::OP_LWL, midc_pkg::OP_LW,
      midc_pkg::OP_LBU, midc_pkg::OP_LHU, midc_pkg::OP_LWR, midc_pkg::OP_SB,
      midc_pkg::OP_SH, midc_pkg::OP_SWL, midc_pkg::OP_SW, midc_pkg::OP_SWR,
      midc_pkg::OP_CACHE:
        s2_cls_nxt.op_base = 1'b1;
      midc_pkg::OP_DADDI, midc_pkg::OP_DADDIU, midc_pkg::OP_LDL, midc_pkg::OP_LDR,
      midc_pkg::OP_LWU, midc_pkg::OP_SDL, midc_pkg::OP_SDR, midc_pkg::OP_LD,
      midc_pkg::OP_SD:
        s2_cls_nxt.op_64 = 1'b1;
      midc_pkg::OP_PREF:    s2_cls_nxt.op_mips4   = 1'b1;
      default: ;
    endcase

    unique case (s1_fn) inside
      midc_pkg::FN_SLL, midc_pkg::FN_SRL, midc_pkg::FN_SRA, midc_pkg::FN_SLLV,
      midc_pkg::FN_SRLV, midc_pkg::FN_SRAV, midc_pkg::FN_JR, midc_pkg::FN_JALR,
      midc_pkg::FN_SYSCALL, midc_pkg::FN_BREAK, midc_pkg::FN_SYNC,
      midc_pkg::FN_MFHI, midc_pkg::FN_MTHI, midc_pkg::FN_MFLO, midc_pkg::FN_MTLO,
      midc_pkg::FN_MULT, midc_pkg::FN_MULTU, midc_pkg::FN_DIV, midc_pkg::FN_DIVU,
      midc_pkg::FN_ADD, midc_pkg::FN_ADDU, midc_pkg::FN_SUB, midc_pkg::FN_SUBU,
      midc_pkg::FN_AND, midc_pkg::FN_OR, midc_pkg::FN_XOR, midc_pkg::FN_NOR,
      midc_pkg::FN_SLT, midc_pkg::FN_SLTU:
        s2_cls_nxt.sp_ok = 1'b1;
      midc_pkg::FN_DSLLV, midc_pkg::FN_DSRLV, midc_pkg::FN_DSRAV,
      midc_pkg::FN_DMULT, midc_pkg::FN_DMULTU, midc_pkg::FN_DDIV, midc_pkg::FN_DDIVU,
      midc_pkg::FN_DADD, midc_pkg::FN_DADDU, midc_pkg::FN_DSUB, midc_pkg::FN_DSUBU,
      midc_pkg::FN_DSLL, midc_pkg::FN_DSRL, midc_pkg::FN_DSRA,
      midc_pkg::FN_DSLL32, midc_pkg::FN_DSRL32, midc_pkg::FN_DSRA32:
        s2_cls_nxt.sp_ok64 = 1'b1;
      midc_pkg::FN_MOVZ, midc_pkg::FN_MOVN:
        s2_cls_nxt.sp_ok4 = 1'b1;
      default: ;
    endcase

    s2_cls_nxt.sp_jump = (s1_fn == midc_pkg::FN_JR) || (s1_fn == midc_pkg::FN_JALR);

    unique case (s1_fn) inside
      midc_pkg::C0_TLBR, midc_pkg::C0_TLBWI, midc_pkg::C0_TLBWR, midc_pkg::C0_TLBP,
      midc_pkg::C0_DERET:
        s2_cls_nxt.co_ok = 1'b1;
      midc_pkg::C0_RFE:      s2_cls_nxt.co_rfe  = 1'b1;
      midc_pkg::C0_ERET:     s2_cls_nxt.co_eret = 1'b1;
      midc_pkg::C0_WAIT:     s2_cls_nxt.co_wait = 1'b1;
      midc_pkg::C0_STANDBY, midc_pkg::C0_SUSPEND:
        s2_cls_nxt.co_pwr = 1'b1;
      midc_pkg::C0_HIBERNATE: begin
        s2_cls_nxt.co_pwr = 1'b1;
        s2_cls_nxt.co_hib = 1'b1;
      end
      default: ;
    endcase

    // The branch-likely REGIMM forms are a subset of the recognised branches.
    s2_cls_nxt.ri_lk = (s1_rt == midc_pkg::RT_BLTZL) || (s1_rt == midc_pkg::RT_BGEZL);
    s2_cls_nxt.ri_br = s2_cls_nxt.ri_lk ||
                       (s1_rt == midc_pkg::RT_BLTZ) || (s1_rt == midc_pkg::RT_BGEZ) ||
                       (s1_rt == midc_pkg::RT_BLTZAL) || (s1_rt == midc_pkg::RT_BGEZAL);

    s2_cls_nxt.c0_ok   = (s1_rs == midc_pkg::RS_MF) || (s1_rs == midc_pkg::RS_MT);
    s2_cls_nxt.c0_ok64 = (s1_rs == midc_pkg::RS_DMF) || (s1_rs == midc_pkg::RS_DMT);
    // Any rs with its top bit set is the CO form.
    s2_cls_nxt.c0_co   = s1_rs[midc_pkg::RegW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_word_r <= s1_word_r;
    s2_pc_r   <= s1_pc_r;
    s2_cls_r  <= s2_cls_nxt;
  end

  // Stage 3: apply the feature switches.
  always_comb begin
    ok_nxt = (s2_cls_r.op_special &&
              (s2_cls_r.sp_ok || (s2_cls_r.sp_ok64 && cfg_r.en64) ||
               (s2_cls_r.sp_ok4 && cfg_r.mips4))) ||
             (s2_cls_r.op_regimm && s2_cls_r.ri_br) ||
             (s2_cls_r.op_cop0 &&
              (s2_cls_r.c0_ok || (s2_cls_r.c0_ok64 && cfg_r.en64) ||
               (s2_cls_r.c0_co &&
                (s2_cls_r.co_ok || (s2_cls_r.co_rfe && cfg_r.rfe) ||
                 ((s2_cls_r.co_eret || s2_cls_r.co_wait) && cfg_r.eret) ||
                 (s2_cls_r.co_pwr && cfg_r.power))))) ||
             s2_cls_r.op_branch || s2_cls_r.op_likely || s2_cls_r.op_base ||
             (s2_cls_r.op_jalx && cfg_r.mips16) ||
             (s2_cls_r.op_fpu && cfg_r.fpu) ||
             (s2_cls_r.op_llsc && cfg_r.llsc) ||
             (s2_cls_r.op_64 && cfg_r.en64) ||
             (s2_cls_r.op_mips4 && cfg_r.mips4);

    br_nxt = (s2_cls_r.op_special && s2_cls_r.sp_jump) ||
             (s2_cls_r.op_regimm && s2_cls_r.ri_br) ||
             s2_cls_r.op_branch || s2_cls_r.op_jalx || s2_cls_r.op_likely;

    lk_nxt = (s2_cls_r.op_regimm && s2_cls_r.ri_lk) || s2_cls_r.op_likely;

    end_nxt = s2_cls_r.op_cop0 && s2_cls_r.c0_co &&
              ((s2_cls_r.co_eret && cfg_r.eret) || (s2_cls_r.co_hib && cfg_r.power));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    br_r   <= br_nxt;
    lk_r   <= lk_nxt;
    end_r  <= end_nxt;
    word_r <= s2_word_r;
    pc_r   <= s2_pc_r;
  end

  assign out_valid         = out_valid_r;
  assign out_recognized    = ok_r;
  assign out_branch_flag   = br_r;
  assign out_likely_flag   = lk_r;
  assign out_block_end     = end_r;
  assign out_guest_pc      = pc_r;
  assign out_major_op      = word_r[31:26];
  assign out_field_rs      = word_r[25:21];
  assign out_field_rt      = word_r[20:16];
  assign out_field_rd      = word_r[15:11];
  assign out_shift_amount  = word_r[10:6];
  assign out_function_code = word_r[5:0];
  assign out_jump_target   = word_r[midc_pkg::TgtW-1:0];

  // A result comes out only for a request that was taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3))
    else $error("result strobe without a matching request");

  a_pc_carry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_guest_pc == $past(in_insn_address, 3))
    else $error("guest address lost in the pipeline");

  a_likely_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_likely_flag |-> out_branch_flag && out_recognized)
    else $error("likely flag on a non-branch");

  a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end |-> out_recognized && out_major_op == midc_pkg::OP_COP0)
    else $error("block end outside a recognised COP0 instruction");

endmodule

`default_nettype wire

// ----- verif/mips_insn_decode_classify_tb.sv -----
// Self-checking testbench for the MIPS instruction decoder and classifier.
`timescale 1ns / 1ps

module mips_insn_decode_classify_tb;

  typedef struct packed {
    logic                         recognized;
    logic                         branch_flag;
    logic                         likely_flag;
    logic                         block_end;
    logic [midc_pkg::WordW-1:0]   guest_pc;
    midc_pkg::op_t                major_op;
    midc_pkg::reg_idx_t           field_rs;
    midc_pkg::reg_idx_t           field_rt;
    midc_pkg::reg_idx_t           field_rd;
    midc_pkg::reg_idx_t           shift_amount;
    midc_pkg::op_t                function_code;
    logic [midc_pkg::TgtW-1:0]    jump_target;
  } decode_result_t;

  // Holds the feature switches as the block should see them and the decodes
  // still owed for accepted requests.
  class decode_scoreboard;
    midc_pkg::cfg_t feat;
    decode_result_t owed_q[$];
    int             errors;

    function new();
      feat   = '0;
      errors = 0;
    endfunction

    function void set_feature(logic [midc_pkg::CfgIdxW-1:0] idx, logic v);
      case (idx)
        midc_pkg::CFG_MIPS4:  feat.mips4  = v;
        midc_pkg::CFG_64BIT:  feat.en64   = v;
        midc_pkg::CFG_ERET:   feat.eret   = v;
        midc_pkg::CFG_RFE:    feat.rfe    = v;
        midc_pkg::CFG_POWER:  feat.power  = v;
        midc_pkg::CFG_MIPS16: feat.mips16 = v;
        midc_pkg::CFG_FPU:    feat.fpu    = v;
        midc_pkg::CFG_LLSC:   feat.llsc   = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_request(logic [midc_pkg::WordW-1:0] w,
                               logic [midc_pkg::WordW-1:0] addr);
      decode_result_t     r;
      midc_pkg::op_t      op;
      midc_pkg::op_t      fn;
      midc_pkg::reg_idx_t rs;
      midc_pkg::reg_idx_t rt;
      logic               ok;
      logic               br;
      logic               lk;
      logic               fin;
      op = w[31:26];
      rs = w[25:21];
      rt = w[20:16];
      fn = w[5:0];
      ok  = 1'b0;
      br  = 1'b0;
      lk  = 1'b0;
      fin = 1'b0;
      case (op)
        midc_pkg::OP_SPECIAL: begin
          // Register jumps count as branches whatever else is decided.
          br = (fn == midc_pkg::FN_JR) || (fn == midc_pkg::FN_JALR);
          case (fn)
            midc_pkg::FN_SLL, midc_pkg::FN_SRL, midc_pkg::FN_SRA, midc_pkg::FN_SLLV,
            midc_pkg::FN_SRLV, midc_pkg::FN_SRAV, midc_pkg::FN_JR, midc_pkg::FN_JALR,
            midc_pkg::FN_SYSCALL, midc_pkg::FN_BREAK, midc_pkg::FN_SYNC,
            midc_pkg::FN_MFHI, midc_pkg::FN_MTHI, midc_pkg::FN_MFLO, midc_pkg::FN_MTLO,
            midc_pkg::FN_MULT, midc_pkg::FN_MULTU, midc_pkg::FN_DIV, midc_pkg::FN_DIVU,
            midc_pkg::FN_ADD, midc_pkg::FN_ADDU, midc_pkg::FN_SUB, midc_pkg::FN_SUBU,
            midc_pkg::FN_AND, midc_pkg::FN_OR, midc_pkg::FN_XOR, midc_pkg::FN_NOR,
            midc_pkg::FN_SLT, midc_pkg::FN_SLTU:
              ok = 1'b1;
            midc_pkg::FN_DSLLV, midc_pkg::FN_DSRLV, midc_pkg::FN_DSRAV,
            midc_pkg::FN_DMULT, midc_pkg::FN_DMULTU, midc_pkg::FN_DDIV,
            midc_pkg::FN_DDIVU, midc_pkg::FN_DADD, midc_pkg::FN_DADDU,
            midc_pkg::FN_DSUB, midc_pkg::FN_DSUBU, midc_pkg::FN_DSLL,
            midc_pkg::FN_DSRL, midc_pkg::FN_DSRA, midc_pkg::FN_DSLL32,
            midc_pkg::FN_DSRL32, midc_pkg::FN_DSRA32:
              ok = feat.en64;
            midc_pkg::FN_MOVZ, midc_pkg::FN_MOVN:
              ok = feat.mips4;
            default: ok = 1'b0;
          endcase
        end
        midc_pkg::OP_REGIMM: begin
          case (rt)
            midc_pkg::RT_BLTZ, midc_pkg::RT_BGEZ, midc_pkg::RT_BLTZAL,
            midc_pkg::RT_BGEZAL: begin
              br = 1'b1;
              ok = 1'b1;
            end
            midc_pkg::RT_BLTZL, midc_pkg::RT_BGEZL: begin
              br = 1'b1;
              lk = 1'b1;
              ok = 1'b1;
            end
            default: ;
          endcase
        end
        midc_pkg::OP_COP0: begin
          // The upper half of the rs range is the CO form.
          fin = rs[4] && ((fn == midc_pkg::C0_ERET && feat.eret) ||
                          (fn == midc_pkg::C0_HIBERNATE && feat.power));
          if (rs == midc_pkg::RS_MF || rs == midc_pkg::RS_MT) begin
            ok = 1'b1;
          end else if (rs == midc_pkg::RS_DMF || rs == midc_pkg::RS_DMT) begin
            ok = feat.en64;
          end else if (rs[4]) begin
            case (fn)
              midc_pkg::C0_TLBR, midc_pkg::C0_TLBWI, midc_pkg::C0_TLBWR,
              midc_pkg::C0_TLBP, midc_pkg::C0_DERET:
                ok = 1'b1;
              midc_pkg::C0_RFE:
                ok = feat.rfe;
              midc_pkg::C0_ERET, midc_pkg::C0_WAIT:
                ok = feat.eret;
              midc_pkg::C0_STANDBY, midc_pkg::C0_SUSPEND, midc_pkg::C0_HIBERNATE:
                ok = feat.power;
              default:
                ok = 1'b0;
            endcase
          end
        end
        midc_pkg::OP_J, midc_pkg::OP_JAL, midc_pkg::OP_BEQ, midc_pkg::OP_BNE,
        midc_pkg::OP_BLEZ, midc_pkg::OP_BGTZ: begin
          br = 1'b1;
          ok = 1'b1;
        end
        midc_pkg::OP_JALX: begin
          br = 1'b1;
          ok = feat.mips16;
        end
        midc_pkg::OP_BEQL, midc_pkg::OP_BNEL, midc_pkg::OP_BLEZL,
        midc_pkg::OP_BGTZL: begin
          br = 1'b1;
          lk = 1'b1;
          ok = 1'b1;
        end
        midc_pkg::OP_COP1:                ok = feat.fpu;
        midc_pkg::OP_LL, midc_pkg::OP_SC: ok = feat.llsc;
        midc_pkg::OP_ADDI, midc_pkg::OP_ADDIU, midc_pkg::OP_SLTI, midc_pkg::OP_SLTIU,
        midc_pkg::OP_ANDI, midc_pkg::OP_ORI, midc_pkg::OP_XORI, midc_pkg::OP_LUI,
        midc_pkg::OP_LB, midc_pkg::OP_LH, midc_pkg::OP_LWL, midc_pkg::OP_LW,
        midc_pkg::OP_LBU, midc_pkg::OP_LHU, midc_pkg::OP_LWR, midc_pkg::OP_SB,
        midc_pkg::OP_SH, midc_pkg::OP_SWL, midc_pkg::OP_SW, midc_pkg::OP_SWR,
        midc_pkg::OP_CACHE:
          ok = 1'b1;
        midc_pkg::OP_DADDI, midc_pkg::OP_DADDIU, midc_pkg::OP_LWU, midc_pkg::OP_SDL,
        midc_pkg::OP_SDR, midc_pkg::OP_LDL, midc_pkg::OP_LDR, midc_pkg::OP_LD,
        midc_pkg::OP_SD:
          ok = feat.en64;
        midc_pkg::OP_PREF:                ok = feat.mips4;
        default: ;
      endcase
      r.recognized    = ok;
      r.branch_flag   = br;
      r.likely_flag   = lk;
      r.block_end     = fin;
      r.guest_pc      = addr;
      r.major_op      = op;
      r.field_rs      = rs;
      r.field_rt      = rt;
      r.field_rd      = w[15:11];
      r.shift_amount  = w[10:6];
      r.function_code = fn;
      r.jump_target   = w[25:0];
      owed_q.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(decode_result_t got);
      decode_result_t exp;
      if (owed_q.size() == 0) begin
        $error("decode result arrived with no request outstanding");
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      check_field("recognized", 32'(exp.recognized), 32'(got.recognized));
      check_field("branch_flag", 32'(exp.branch_flag), 32'(got.branch_flag));
      check_field("likely_flag", 32'(exp.likely_flag), 32'(got.likely_flag));
      check_field("block_end", 32'(exp.block_end), 32'(got.block_end));
      check_field("guest_pc", exp.guest_pc, got.guest_pc);
      check_field("major_op", 32'(exp.major_op), 32'(got.major_op));
      check_field("field_rs", 32'(exp.field_rs), 32'(got.field_rs));
      check_field("field_rt", 32'(exp.field_rt), 32'(got.field_rt));
      check_field("field_rd", 32'(exp.field_rd), 32'(got.field_rd));
      check_field("shift_amount", 32'(exp.shift_amount), 32'(got.shift_amount));
      check_field("function_code", 32'(exp.function_code), 32'(got.function_code));
      check_field("jump_target", 32'(exp.jump_target), 32'(got.jump_target));
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [midc_pkg::WordW-1:0]    in_insn_word;
  logic [midc_pkg::WordW-1:0]    in_insn_address;
  logic                          cfg_we;
  logic [midc_pkg::CfgIdxW-1:0]  cfg_index;
  logic                          cfg_wdata;
  logic                          out_valid;
  logic                          out_recognized;
  logic                          out_branch_flag;
  logic                          out_likely_flag;
  logic                          out_block_end;
  logic [midc_pkg::WordW-1:0]    out_guest_pc;
  logic [midc_pkg::OpW-1:0]      out_major_op;
  logic [midc_pkg::RegW-1:0]     out_field_rs;
  logic [midc_pkg::RegW-1:0]     out_field_rt;
  logic [midc_pkg::RegW-1:0]     out_field_rd;
  logic [midc_pkg::RegW-1:0]     out_shift_amount;
  logic [midc_pkg::OpW-1:0]      out_function_code;
  logic [midc_pkg::TgtW-1:0]     out_jump_target;

  decode_scoreboard sb = new();
  bit               steady;

  mips_insn_decode_classify u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_insn_word      (in_insn_word),
    .in_insn_address   (in_insn_address),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_recognized    (out_recognized),
    .out_branch_flag   (out_branch_flag),
    .out_likely_flag   (out_likely_flag),
    .out_block_end     (out_block_end),
    .out_guest_pc      (out_guest_pc),
    .out_major_op      (out_major_op),
    .out_field_rs      (out_field_rs),
    .out_field_rt      (out_field_rt),
    .out_field_rd      (out_field_rd),
    .out_shift_amount  (out_shift_amount),
    .out_function_code (out_function_code),
    .out_jump_target   (out_jump_target)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result({out_recognized, out_branch_flag, out_likely_flag,
                       out_block_end, out_guest_pc, out_major_op, out_field_rs,
                       out_field_rt, out_field_rd, out_shift_amount,
                       out_function_code, out_jump_target});
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Mostly back to back or short gaps, now and then a long pause; while
  // steady is set requests follow one another with no gap at all.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(63) == 0) steady = !steady;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic send_request(input logic [midc_pkg::WordW-1:0] w,
                              input logic [midc_pkg::WordW-1:0] addr);
    int gap;
    @(negedge clk);
    start           = 1'b1;
    in_insn_word    = w;
    in_insn_address = addr;
    do @(posedge clk); while (busy);
    sb.note_request(w, addr);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start           = 1'b0;
      in_insn_word    = $urandom();
      in_insn_address = $urandom();
      repeat (gap - 1) @(posedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // Pipeline is three stages deep; give it a little more.
    repeat (4) @(negedge clk);
  endtask

  task automatic write_features(input midc_pkg::cfg_t f);
    logic [midc_pkg::CfgIdxW-1:0] idx [8];
    logic                         val [8];
    idx = '{midc_pkg::CFG_MIPS4, midc_pkg::CFG_64BIT, midc_pkg::CFG_ERET,
            midc_pkg::CFG_RFE, midc_pkg::CFG_POWER, midc_pkg::CFG_MIPS16,
            midc_pkg::CFG_FPU, midc_pkg::CFG_LLSC};
    val = '{f.mips4, f.en64, f.eret, f.rfe, f.power, f.mips16, f.fpu, f.llsc};
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_index = idx[3'(i)];
      cfg_wdata = val[3'(i)];
      @(posedge clk);
      sb.set_feature(idx[3'(i)], val[3'(i)]);
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [midc_pkg::WordW-1:0] random_address();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // Biased towards the encodings that the feature switches and the
  // sub-opcode decodes care about; the rest is fully random words.
  function automatic logic [midc_pkg::WordW-1:0] random_word();
    logic [midc_pkg::WordW-1:0] w;
    int                         r;
    midc_pkg::reg_idx_t         ri_codes [6];
    midc_pkg::reg_idx_t         c0_rs [4];
    midc_pkg::op_t              co_codes [11];
    midc_pkg::op_t              gated [14];
    ri_codes = '{midc_pkg::RT_BLTZ, midc_pkg::RT_BGEZ, midc_pkg::RT_BLTZL,
                 midc_pkg::RT_BGEZL, midc_pkg::RT_BLTZAL, midc_pkg::RT_BGEZAL};
    c0_rs    = '{midc_pkg::RS_MF, midc_pkg::RS_DMF, midc_pkg::RS_MT, midc_pkg::RS_DMT};
    co_codes = '{midc_pkg::C0_TLBR, midc_pkg::C0_TLBWI, midc_pkg::C0_TLBWR,
                 midc_pkg::C0_TLBP, midc_pkg::C0_RFE, midc_pkg::C0_ERET,
                 midc_pkg::C0_DERET, midc_pkg::C0_WAIT, midc_pkg::C0_STANDBY,
                 midc_pkg::C0_SUSPEND, midc_pkg::C0_HIBERNATE};
    gated    = '{midc_pkg::OP_JALX, midc_pkg::OP_COP1, midc_pkg::OP_LL,
                 midc_pkg::OP_SC, midc_pkg::OP_PREF, midc_pkg::OP_DADDI,
                 midc_pkg::OP_DADDIU, midc_pkg::OP_LWU, midc_pkg::OP_LDL,
                 midc_pkg::OP_LDR, midc_pkg::OP_SDL, midc_pkg::OP_SDR,
                 midc_pkg::OP_LD, midc_pkg::OP_SD};
    w = $urandom();
    r = $urandom_range(99);
    if (r < 22) begin
      w[31:26] = midc_pkg::OP_SPECIAL;
    end else if (r < 34) begin
      w[31:26] = midc_pkg::OP_REGIMM;
      if ($urandom_range(1)) w[20:16] = ri_codes[3'($urandom_range(5))];
    end else if (r < 56) begin
      w[31:26] = midc_pkg::OP_COP0;
      case ($urandom_range(4))
        0, 1:    w[25:21] = c0_rs[2'($urandom_range(3))];
        2, 3:    w[25:21] = 5'($urandom_range(31, 16));
        default: ;
      endcase
      if (w[25] && $urandom_range(9) < 7) w[5:0] = co_codes[4'($urandom_range(10))];
    end else if (r < 70) begin
      w[31:26] = gated[4'($urandom_range(13))];
    end
    return w;
  endfunction

  initial begin
    midc_pkg::cfg_t f;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_insn_word    = '0;
    in_insn_address = '0;
    cfg_we          = 1'b0;
    cfg_index       = midc_pkg::CFG_MIPS4;
    cfg_wdata       = 1'b0;
    steady          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every feature off: gated encodings must be refused, and neither ERET
    // nor HIBERNATE may end a block.
    write_features('0);
    send_request('0, '0);
    send_request('1, '1);
    send_request({midc_pkg::OP_JALX, 26'h3ffffff}, random_address());
    send_request({midc_pkg::OP_COP0, 5'd16, 15'h0, midc_pkg::C0_ERET}, random_address());
    send_request({midc_pkg::OP_COP0, 5'd31, 15'h7fff, midc_pkg::C0_HIBERNATE},
                 random_address());
    send_request({midc_pkg::OP_COP1, 26'h1555555}, random_address());
    send_request({midc_pkg::OP_LL, 26'h2aaaaaa}, random_address());
    send_request({midc_pkg::OP_SPECIAL, 20'h12345, midc_pkg::FN_MOVZ}, random_address());
    send_request({midc_pkg::OP_COP0, midc_pkg::RS_DMF, 16'h6000, 5'h0}, random_address());
    send_request({midc_pkg::OP_COP0, 5'd16, 15'h0, midc_pkg::C0_RFE}, random_address());
    send_request({midc_pkg::OP_PREF, 26'h0}, random_address());
    send_request({midc_pkg::OP_SPECIAL, 5'd31, 15'h7fff, midc_pkg::FN_JR},
                 random_address());
    drain();

    // Every feature on.
    write_features('1);
    send_request({midc_pkg::OP_COP0, 5'd16, 15'h0, midc_pkg::C0_ERET}, random_address());
    send_request({midc_pkg::OP_COP0, 5'd31, 15'h0, midc_pkg::C0_HIBERNATE},
                 random_address());
    send_request({midc_pkg::OP_COP0, 5'd24, 15'h1234, midc_pkg::C0_WAIT},
                 random_address());
    send_request({midc_pkg::OP_COP0, 5'd16, 15'h0, midc_pkg::C0_RFE}, random_address());
    send_request({midc_pkg::OP_JALX, 26'h0}, random_address());
    // BLTZALL is not in the recognized REGIMM set.
    send_request({midc_pkg::OP_REGIMM, 5'd4, 5'd18, 16'hffff}, random_address());
    send_request({midc_pkg::OP_REGIMM, 5'd7, midc_pkg::RT_BGEZL, 16'h8000},
                 random_address());
    send_request({midc_pkg::OP_BEQL, 26'h3ffffff}, random_address());
    // COP0 with an rs below the CO range that is no move.
    send_request({midc_pkg::OP_COP0, 5'd2, 21'h0}, random_address());
    send_request({midc_pkg::OP_SC, 26'h155aa55}, random_address());
    send_request({midc_pkg::OP_SPECIAL, 20'h0, midc_pkg::FN_JALR}, random_address());
    send_request({midc_pkg::OP_SPECIAL, 20'hfffff, midc_pkg::FN_DSRA32},
                 random_address());
    send_request('1, '0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) f = '0;
      else if (ph == 1) f = '1;
      else f = midc_pkg::cfg_t'(8'($urandom()));
      write_features(f);
      steady = ($urandom_range(3) == 0);
      for (int n = 0; n < 185; n++) send_request(random_word(), random_address());
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
